// ===== rtl/mandelbrot_pixel_escape_time_defines.svh =====
// assertion macros shared by the escape-time block
`ifndef MANDELBROT_PIXEL_ESCAPE_TIME_DEFINES_SVH
`define MANDELBROT_PIXEL_ESCAPE_TIME_DEFINES_SVH

// antecedent holds in a cycle, consequent holds in the same cycle
`define MBE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("escape-time block assertion failed");

// antecedent holds in a cycle, consequent holds in the next cycle
`define MBE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("escape-time block assertion failed");

`endif

// ===== rtl/mbe_pkg.sv =====
// types, constants and helpers of the escape-time block
package mbe_pkg;

    localparam int FRAC_BITS = 28;
    localparam int ITER_BITS = 16;

    localparam int FX_W     = FRAC_BITS + 4;
    localparam int COORD_W  = 15;
    localparam int LIMIT_W  = 16;
    localparam int COLOR_W  = 24;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int M_W      = 18;
    localparam int NUMER_W  = M_W + FRAC_BITS - 1;
    localparam int MAG_W    = FX_W + 1;
    localparam int DCNT_W   = $clog2(NUMER_W + 1);
    localparam int PROD_W   = 2 * FX_W;
    localparam int EXT_W    = FX_W + 6;
    localparam int CPROD_W  = ITER_BITS + COLOR_W;

    localparam int Q_AW     = 1;
    localparam int Q_DEPTH  = 1 << Q_AW;
    localparam int Q_CW     = Q_AW + 1;

    localparam logic [M_W-1:0]    MAP_MUL   = M_W'(5);
    localparam logic [MAG_W-1:0]  FX_SAT16  = {1'b1, {FX_W{1'b0}}};
    localparam logic signed [FX_W-1:0] FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
    localparam logic signed [FX_W-1:0] FX_MIN = {1'b1, {(FX_W-1){1'b0}}};
    localparam logic [FX_W-1:0]   C_1_6     = FX_W'((64'd8 << FRAC_BITS) / 64'd5);
    localparam logic [FX_W-1:0]   C_1_25    = FX_W'(64'd5 << (FRAC_BITS - 2));
    localparam logic [EXT_W-1:0]  FOUR_FX   = EXT_W'(64'd4 << FRAC_BITS);
    localparam logic [31:0]       ITER_CAP  = 32'((64'd1 << ITER_BITS) - 64'd1);
    localparam logic [COLOR_W-1:0] COLOR_WHITE = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] COLOR_MUL   = 24'h081021;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_LIMIT  = 2'd2;

    localparam logic [15:0] IMAGE_WIDTH_RST  = 16'd512;
    localparam logic [15:0] IMAGE_HEIGHT_RST = 16'd512;
    localparam logic [15:0] ITER_LIMIT_RST   = 16'd1000;

    typedef struct packed {
        logic signed [FX_W-1:0] cre;
        logic signed [FX_W-1:0] cim;
    } point_t;

    typedef struct packed {
        logic [Q_CW-1:0] count;
        logic            push;
    } q_stat_t;

    typedef struct packed {
        logic eval;
    } b_stat_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV_RE,
        F_DIV_IM,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_EVAL
    } back_state_t;

    // clamp to the fixed-point range [-8, 8 - lsb]
    function automatic logic signed [FX_W-1:0] sat_fx(input logic signed [EXT_W-1:0] v);
        logic signed [EXT_W-1:0] hi;
        logic signed [EXT_W-1:0] lo;
        hi = EXT_W'(FX_MAX);
        lo = EXT_W'(FX_MIN);
        if (v > hi)
            sat_fx = FX_MAX;
        else if (v < lo)
            sat_fx = FX_MIN;
        else
            sat_fx = FX_W'(v);
    endfunction

endpackage

// ===== rtl/mbe_if.sv =====
// valid/ready channel interfaces for pixel coordinates and colors
interface mbe_pix_if;
    logic                         valid;
    logic                         ready;
    logic [mbe_pkg::COORD_W-1:0]  pixel_x;
    logic [mbe_pkg::COORD_W-1:0]  pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface mbe_color_if;
    logic                         valid;
    logic                         ready;
    logic [mbe_pkg::COLOR_W-1:0]  pixel_color;

    modport source (output valid, output pixel_color, input ready);
    modport sink   (input valid, input pixel_color, output ready);
endinterface

// ===== rtl/mandelbrot_pixel_escape_time.sv =====
// top level of the mandelbrot escape-time pixel block
// Each transfer on the pixel channel carries one coordinate (pixel_x, pixel_y) and gives
// exactly one transfer on the color channel, in order. The front end maps the coordinate
// to c in Q4.28 with a one-bit-per-cycle divider, real part then imaginary part, and
// hands c to a two-entry queue. The back end runs the z*z + c loop, alternating a
// multiply state that forms the three products with an evaluate state that tests the
// bound and updates z; that loop sets the sustained rate. The front end works on the
// next pixel meanwhile. A finished color waits in an output register; the loop only
// holds in its last evaluate cycle while the previous color is still waiting there.
// Registers are written and read over the APB port: image_width at 0x0, image_height at
// 0x4, iteration_limit at 0x8. Write them only while no pixel is in flight. There is no
// clearing pass after reset.
`include "mandelbrot_pixel_escape_time_defines.svh"

module mandelbrot_pixel_escape_time (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mbe_pkg::ADDR_W-1:0]   paddr,
    input  logic [mbe_pkg::DATA_W-1:0]   pwdata,
    output logic [mbe_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    mbe_pix_if.sink                      pixel,
    mbe_color_if.source                  color
);

    // configuration registers
    logic [mbe_pkg::COORD_W-1:0] width_reg, width_next;
    logic [mbe_pkg::COORD_W-1:0] height_reg, height_next;
    logic [mbe_pkg::LIMIT_W-1:0] limit_reg, limit_next;
    logic                        wr_en;
    logic [1:0]                  reg_idx;

    // front to queue to back
    logic                        q_push;
    logic                        q_full;
    logic                        q_valid;
    logic                        q_pop;
    mbe_pkg::point_t             q_in;
    mbe_pkg::point_t             q_out;
    mbe_pkg::q_stat_t            q_stat;
    mbe_pkg::b_stat_t            b_stat;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // register write decode, an unknown index is dropped
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        limit_next  = limit_reg;
        if (wr_en)
        begin
            case (reg_idx)
                mbe_pkg::REG_WIDTH:  width_next  = pwdata[mbe_pkg::COORD_W-1:0];
                mbe_pkg::REG_HEIGHT: height_next = pwdata[mbe_pkg::COORD_W-1:0];
                mbe_pkg::REG_LIMIT:  limit_next  = pwdata[mbe_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // register read mux
    always_comb
    begin
        case (reg_idx)
            mbe_pkg::REG_WIDTH:  prdata = mbe_pkg::DATA_W'(width_reg);
            mbe_pkg::REG_HEIGHT: prdata = mbe_pkg::DATA_W'(height_reg);
            mbe_pkg::REG_LIMIT:  prdata = mbe_pkg::DATA_W'(limit_reg);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= mbe_pkg::IMAGE_WIDTH_RST[mbe_pkg::COORD_W-1:0];
            height_reg <= mbe_pkg::IMAGE_HEIGHT_RST[mbe_pkg::COORD_W-1:0];
            limit_reg  <= mbe_pkg::ITER_LIMIT_RST;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            limit_reg  <= limit_next;
        end
    end

    // coordinate mapping
    mbe_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel        (pixel),
        .image_width  (width_reg),
        .image_height (height_reg),
        .push         (q_push),
        .push_data    (q_in),
        .q_full       (q_full)
    );

    // decoupling queue
    mbe_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_data  (q_out),
        .stat      (q_stat)
    );

    // iteration loop and color output
    mbe_iter u_iter (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_data          (q_out),
        .q_pop           (q_pop),
        .iteration_limit (limit_reg),
        .color           (color),
        .stat            (b_stat)
    );

    // queue never holds more than its depth
    `MBE_ASSERT_IMP(a_q_bound, 1'b1, q_stat.count <= mbe_pkg::Q_CW'(mbe_pkg::Q_DEPTH))
    // front end only pushes when there is room
    `MBE_ASSERT_IMP(a_q_room, q_stat.push, q_stat.count < mbe_pkg::Q_CW'(mbe_pkg::Q_DEPTH))
    // a new color only ever comes out of the loop's evaluate cycle
    `MBE_ASSERT_IMP(a_out_src, $rose(color.valid), $past(b_stat.eval))

endmodule

// ===== rtl/mbe_div.sv =====
// restoring divider, one quotient bit per cycle, saturated magnitude out
module mbe_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [mbe_pkg::NUMER_W-1:0]   numer,
    input  logic [mbe_pkg::COORD_W-1:0]   denom,
    output logic                          done,
    output logic [mbe_pkg::MAG_W-1:0]     mag
);

    logic [mbe_pkg::NUMER_W-1:0] num_reg, num_next;
    logic [mbe_pkg::NUMER_W-1:0] quo_reg, quo_next;
    logic [mbe_pkg::COORD_W-1:0] rem_reg, rem_next;
    logic [mbe_pkg::DCNT_W-1:0]  cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;

    logic [mbe_pkg::COORD_W:0]   rem_shift;
    logic [mbe_pkg::COORD_W:0]   rem_sub;
    logic                        fits;

    always_comb
    begin
        rem_shift = {rem_reg, num_reg[mbe_pkg::NUMER_W-1]};
        rem_sub   = rem_shift - {1'b0, denom};
        fits      = rem_shift >= {1'b0, denom};
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = numer;
            quo_next  = '0;
            rem_next  = '0;
            cnt_next  = mbe_pkg::DCNT_W'(mbe_pkg::NUMER_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[mbe_pkg::NUMER_W-2:0], 1'b0};
            quo_next = {quo_reg[mbe_pkg::NUMER_W-2:0], fits};
            rem_next = fits ? rem_sub[mbe_pkg::COORD_W-1:0]
                            : rem_shift[mbe_pkg::COORD_W-1:0];
            cnt_next = cnt_reg - mbe_pkg::DCNT_W'(1);
            if (cnt_reg == mbe_pkg::DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    // quotient of 16 or more clamps to 16
    assign mag  = (|quo_reg[mbe_pkg::NUMER_W-1:mbe_pkg::FX_W]) ? mbe_pkg::FX_SAT16
                : {1'b0, quo_reg[mbe_pkg::FX_W-1:0]};
    assign done = done_reg;

endmodule

// ===== rtl/mbe_fifo.sv =====
// short queue of mapped points between front and back
module mbe_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mbe_pkg::point_t   push_data,
    output logic              full,
    output logic              pop_valid,
    input  logic              pop,
    output mbe_pkg::point_t   pop_data,
    output mbe_pkg::q_stat_t  stat
);

    mbe_pkg::point_t           mem_reg [mbe_pkg::Q_DEPTH];
    logic [mbe_pkg::Q_AW-1:0]  wr_reg, wr_next;
    logic [mbe_pkg::Q_AW-1:0]  rd_reg, rd_next;
    logic [mbe_pkg::Q_CW-1:0]  cnt_reg, cnt_next;

    always_comb
    begin
        wr_next  = push ? wr_reg + mbe_pkg::Q_AW'(1) : wr_reg;
        rd_next  = pop  ? rd_reg + mbe_pkg::Q_AW'(1) : rd_reg;
        cnt_next = cnt_reg + mbe_pkg::Q_CW'(push) - mbe_pkg::Q_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

    assign full       = cnt_reg == mbe_pkg::Q_CW'(mbe_pkg::Q_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_data   = mem_reg[rd_reg];
    assign stat.count = cnt_reg;
    assign stat.push  = push;

endmodule

// ===== rtl/mbe_front.sv =====
// front end: takes a pixel and maps it to the complex point c
module mbe_front (
    input  logic                         clk,
    input  logic                         rst_n,
    mbe_pix_if.sink                      pixel,
    input  logic [mbe_pkg::COORD_W-1:0]  image_width,
    input  logic [mbe_pkg::COORD_W-1:0]  image_height,
    output logic                         push,
    output mbe_pkg::point_t              push_data,
    input  logic                         q_full
);

    mbe_pkg::front_state_t        state_reg, state_next;
    logic [mbe_pkg::COORD_W-1:0]  px_reg, px_next;
    logic [mbe_pkg::COORD_W-1:0]  py_reg, py_next;
    logic signed [mbe_pkg::FX_W-1:0] cre_reg, cre_next;
    logic signed [mbe_pkg::FX_W-1:0] cim_reg, cim_next;

    logic                         div_start;
    logic                         div_done;
    logic [mbe_pkg::NUMER_W-1:0]  div_numer;
    logic [mbe_pkg::COORD_W-1:0]  div_denom;
    logic [mbe_pkg::MAG_W-1:0]    div_mag;

    logic signed [mbe_pkg::COORD_W:0] im_n;
    logic [mbe_pkg::COORD_W:0]    im_abs;
    logic [mbe_pkg::M_W-1:0]      m_val;
    logic                         zero_sel;
    logic                         neg_sel;
    logic [mbe_pkg::MAG_W-1:0]    mag_eff;
    logic signed [mbe_pkg::EXT_W-1:0] mag_s;
    logic signed [mbe_pkg::EXT_W-1:0] off_s;
    logic signed [mbe_pkg::FX_W-1:0]  coord;

    mbe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (div_denom),
        .done  (div_done),
        .mag   (div_mag)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mbe_pkg::F_IDLE:
                if (pixel.valid)
                    state_next = mbe_pkg::F_DIV_RE;
            mbe_pkg::F_DIV_RE:
                if (div_done)
                    state_next = mbe_pkg::F_DIV_IM;
            mbe_pkg::F_DIV_IM:
                if (div_done)
                    state_next = mbe_pkg::F_PUSH;
            mbe_pkg::F_PUSH:
                if (!q_full)
                    state_next = mbe_pkg::F_IDLE;
            default:
                state_next = mbe_pkg::F_IDLE;
        endcase
    end

    always_comb
    begin
        pixel.ready = state_reg == mbe_pkg::F_IDLE;
        push        = (state_reg == mbe_pkg::F_PUSH) && !q_full;
        div_start   = ((state_reg == mbe_pkg::F_IDLE) && pixel.valid)
                   || ((state_reg == mbe_pkg::F_DIV_RE) && div_done);

        // imaginary numerator is height - y, signed
        im_n   = $signed({1'b0, image_height}) - $signed({1'b0, py_reg});
        im_abs = im_n[mbe_pkg::COORD_W] ? -im_n : im_n;

        if (state_reg == mbe_pkg::F_IDLE)
            m_val = mbe_pkg::M_W'(pixel.pixel_x) * mbe_pkg::MAP_MUL;
        else
            m_val = mbe_pkg::M_W'(im_abs[mbe_pkg::COORD_W-1:0]) * mbe_pkg::MAP_MUL;
        // the divisor is read on every step, so it follows the division in progress
        if ((state_reg == mbe_pkg::F_IDLE) || (state_reg == mbe_pkg::F_DIV_RE))
            div_denom = image_width;
        else
            div_denom = image_height;
        div_numer = {m_val, {(mbe_pkg::FRAC_BITS-1){1'b0}}};

        // a zero numerator maps to zero even for a zero divisor
        if (state_reg == mbe_pkg::F_DIV_RE)
        begin
            zero_sel = px_reg == '0;
            neg_sel  = 1'b0;
            off_s    = $signed(mbe_pkg::EXT_W'(mbe_pkg::C_1_6));
        end
        else
        begin
            zero_sel = im_n == '0;
            neg_sel  = im_n[mbe_pkg::COORD_W];
            off_s    = $signed(mbe_pkg::EXT_W'(mbe_pkg::C_1_25));
        end
        mag_eff = zero_sel ? '0 : div_mag;
        mag_s   = $signed(mbe_pkg::EXT_W'(mag_eff));
        coord   = mbe_pkg::sat_fx((neg_sel ? -mag_s : mag_s) - off_s);

        px_next  = pixel.ready && pixel.valid ? pixel.pixel_x : px_reg;
        py_next  = pixel.ready && pixel.valid ? pixel.pixel_y : py_reg;
        cre_next = ((state_reg == mbe_pkg::F_DIV_RE) && div_done) ? coord : cre_reg;
        cim_next = ((state_reg == mbe_pkg::F_DIV_IM) && div_done) ? coord : cim_reg;

        push_data.cre = cre_reg;
        push_data.cim = cim_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mbe_pkg::F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        px_reg  <= px_next;
        py_reg  <= py_next;
        cre_reg <= cre_next;
        cim_reg <= cim_next;
    end

endmodule

// ===== rtl/mbe_iter.sv =====
// back end: z = z*z + c loop and color lookup with an output register
module mbe_iter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  mbe_pkg::point_t              q_data,
    output logic                         q_pop,
    input  logic [mbe_pkg::LIMIT_W-1:0]  iteration_limit,
    mbe_color_if.source                  color,
    output mbe_pkg::b_stat_t             stat
);

    mbe_pkg::back_state_t            state_reg, state_next;
    logic signed [mbe_pkg::FX_W-1:0] cre_reg, cre_next;
    logic signed [mbe_pkg::FX_W-1:0] cim_reg, cim_next;
    logic signed [mbe_pkg::FX_W-1:0] re_reg, re_next;
    logic signed [mbe_pkg::FX_W-1:0] im_reg, im_next;
    logic [mbe_pkg::ITER_BITS-1:0]   cnt_reg, cnt_next;
    logic signed [mbe_pkg::PROD_W-1:0] prr_reg, prr_next;
    logic signed [mbe_pkg::PROD_W-1:0] pii_reg, pii_next;
    logic signed [mbe_pkg::PROD_W-1:0] pri_reg, pri_next;
    logic                            ovalid_reg, ovalid_next;
    logic [mbe_pkg::COLOR_W-1:0]     color_reg, color_next;

    logic [31:0]                     lim32;
    logic [31:0]                     lim_cap;
    logic [mbe_pkg::ITER_BITS-1:0]   lim_eff;
    logic signed [mbe_pkg::EXT_W-1:0] re2;
    logic signed [mbe_pkg::EXT_W-1:0] im2;
    logic signed [mbe_pkg::EXT_W-1:0] rim;
    logic                            bounded;
    logic                            finish;
    logic                            out_free;
    logic                            load_out;
    logic [mbe_pkg::CPROD_W-1:0]     cprod;

    always_comb
    begin
        lim32   = 32'(iteration_limit);
        lim_cap = (lim32 > mbe_pkg::ITER_CAP) ? mbe_pkg::ITER_CAP : lim32;
        lim_eff = lim_cap[mbe_pkg::ITER_BITS-1:0];

        re2     = mbe_pkg::EXT_W'(prr_reg >>> mbe_pkg::FRAC_BITS);
        im2     = mbe_pkg::EXT_W'(pii_reg >>> mbe_pkg::FRAC_BITS);
        rim     = mbe_pkg::EXT_W'(pri_reg >>> (mbe_pkg::FRAC_BITS - 1));
        bounded = (re2 + im2) < $signed(mbe_pkg::FOUR_FX);
        finish  = (cnt_reg >= lim_eff) || !bounded;
        out_free = !ovalid_reg || color.ready;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mbe_pkg::B_IDLE:
                if (q_valid)
                    state_next = mbe_pkg::B_MUL;
            mbe_pkg::B_MUL:
                state_next = mbe_pkg::B_EVAL;
            mbe_pkg::B_EVAL:
                if (!finish)
                    state_next = mbe_pkg::B_MUL;
                else if (out_free)
                    state_next = mbe_pkg::B_IDLE;
            default:
                state_next = mbe_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop    = (state_reg == mbe_pkg::B_IDLE) && q_valid;
        load_out = (state_reg == mbe_pkg::B_EVAL) && finish && out_free;

        cre_next = q_pop ? q_data.cre : cre_reg;
        cim_next = q_pop ? q_data.cim : cim_reg;
        re_next  = re_reg;
        im_next  = im_reg;
        cnt_next = cnt_reg;
        if (q_pop)
        begin
            re_next  = '0;
            im_next  = '0;
            cnt_next = '0;
        end
        else if ((state_reg == mbe_pkg::B_EVAL) && !finish)
        begin
            re_next  = mbe_pkg::sat_fx(re2 - im2 + mbe_pkg::EXT_W'(cre_reg));
            im_next  = mbe_pkg::sat_fx(rim + mbe_pkg::EXT_W'(cim_reg));
            cnt_next = cnt_reg + mbe_pkg::ITER_BITS'(1);
        end

        // one multiply stage per iteration, evaluated in the next cycle
        prr_next = mbe_pkg::PROD_W'(re_reg) * mbe_pkg::PROD_W'(re_reg);
        pii_next = mbe_pkg::PROD_W'(im_reg) * mbe_pkg::PROD_W'(im_reg);
        pri_next = mbe_pkg::PROD_W'(re_reg) * mbe_pkg::PROD_W'(im_reg);

        cprod       = mbe_pkg::CPROD_W'(cnt_reg) * mbe_pkg::CPROD_W'(mbe_pkg::COLOR_MUL);
        color_next  = color_reg;
        if (load_out)
            color_next = bounded ? mbe_pkg::COLOR_WHITE : cprod[mbe_pkg::COLOR_W-1:0];
        ovalid_next = (ovalid_reg && !color.ready) || load_out;

        color.valid       = ovalid_reg;
        color.pixel_color = color_reg;
        stat.eval         = state_reg == mbe_pkg::B_EVAL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mbe_pkg::B_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cre_reg   <= cre_next;
        cim_reg   <= cim_next;
        re_reg    <= re_next;
        im_reg    <= im_next;
        cnt_reg   <= cnt_next;
        prr_reg   <= prr_next;
        pii_reg   <= pii_next;
        pri_reg   <= pri_next;
        color_reg <= color_next;
    end

endmodule
